[hw/rtl/dda_pkg.sv]
`default_nettype none
package dda_pkg;

	// Operand capacity in digits.
	localparam int MAX_DIGITS = 32;
	// Address width of an operand store.
	localparam int DIG_AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	// Width of a digit count; it also addresses the scratch store.
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int WORK_DEPTH = MAX_DIGITS + 1;

	localparam logic [3:0] DIGIT_MAX = 4'd9;
	localparam logic [4:0] DEC_BASE = 5'd10;

	localparam logic [2:0] REQ_LOAD_A = 3'd0;
	localparam logic [2:0] REQ_LOAD_B = 3'd1;
	localparam logic [2:0] REQ_SUM = 3'd2;
	localparam logic [2:0] REQ_DIFF = 3'd3;
	localparam logic [2:0] REQ_CLEAR = 3'd4;

	localparam logic [1:0] ST_SUM = 2'd0;
	localparam logic [1:0] ST_DIFF = 2'd1;
	localparam logic [1:0] ST_NA = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADD,
		S_FIN,
		S_EMIT
	} state_t;

endpackage
`default_nettype wire

[hw/rtl/decimal_digit_add_subtract.sv]
`default_nettype none
// Decimal add / subtract unit for two unsigned operands held as digit strings.
// A request is taken on a rising edge where start is high and busy is low.
// Load requests append one digit (most significant first) to operand A or B
// and leave busy low, so loads stream at one per cycle.
// Clear empties both operands. Loads and clear give no result.
// A sum or difference request with an empty or invalid operand returns one
// not-available result in the cycle after it is taken.
// Otherwise the block walks the operands once from the least significant
// digit through the operand stores into a scratch store, then settles the
// carry or borrow. A difference that ends in a borrow (A below B) returns
// one not-available result; else the scratch store is read back out one
// digit per cycle. Busy stays high throughout; the single read port of the
// scratch store sets the output pass.
// Results appear on status, digit_res and last, marked by strobe for exactly
// one cycle; the receiver cannot stall, so no result is ever held back.
// Reset empties both operands and clears the invalid marks; the digit stores
// themselves are not cleared since nothing reads past a count.
module decimal_digit_add_subtract (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [2:0] req_type,
	input  wire logic [3:0] digit,
	output logic            strobe,
	output logic [1:0]      status,
	output logic [3:0]      digit_res,
	output logic            last
);
	import dda_pkg::*;

	// Operand stores and the scratch store, all with registered reads.
	logic [3:0] a_mem [MAX_DIGITS];
	logic [3:0] b_mem [MAX_DIGITS];
	logic [3:0] work_mem [WORK_DEPTH];
	logic [3:0] a_rd_q, b_rd_q, w_rd_q;

	state_t state_q, state_d;

	logic [CNT_W-1:0] a_count_q, b_count_q;
	logic             a_inv_q, b_inv_q;
	logic             op_sum_q;     // 1 for a sum request, 0 for a difference
	logic [CNT_W-1:0] len_q;        // digits walked in the first pass
	logic [CNT_W-1:0] p_q;          // first-pass issue position
	logic             carry_q;      // carry for a sum, borrow for a difference
	logic [CNT_W-1:0] e_q;          // scratch read position in the output pass
	logic [CNT_W-1:0] end_q;
	logic             e_issue_q;
	logic             skip_q;       // still inside leading zeros of a difference

	// Read-stage registers, aligned with the memory read data.
	logic             add_v_s1;
	logic [CNT_W-1:0] p_s1;
	logic             ain_s1, bin_s1;
	logic             ev_s1;
	logic             elast_s1;

	logic             accept;
	logic             na;
	logic             add_issue;
	logic             emit_issue;
	logic             add_done;
	logic [CNT_W-1:0] a_off, b_off;
	logic [CNT_W-1:0] max_len;

	logic [3:0] d1, d2;
	logic [4:0] sum5, sub5, diff5, rsum5;
	logic       ge10, lt;

	logic             w_en;
	logic [CNT_W-1:0] w_addr;
	logic [3:0]       w_data;

	logic       out_set;
	logic [1:0] out_st;
	logic [3:0] out_dig;
	logic       out_last;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign na     = (a_count_q == '0) || (b_count_q == '0) || a_inv_q || b_inv_q;
	assign max_len = (a_count_q > b_count_q) ? a_count_q : b_count_q;

	// First pass walks from the least significant digit upward.
	assign add_issue = (state_q == S_ADD) && (p_q < len_q);
	assign a_off = a_count_q - CNT_W'(1) - p_q;
	assign b_off = b_count_q - CNT_W'(1) - p_q;
	assign add_done = add_v_s1 && (p_s1 == len_q - CNT_W'(1));

	assign emit_issue = (state_q == S_EMIT) && e_issue_q;

	// One digit of the add or subtract, with leading positions read as zero.
	assign d1    = ain_s1 ? a_rd_q : 4'd0;
	assign d2    = bin_s1 ? b_rd_q : 4'd0;
	assign sum5  = {1'b0, d1} + {1'b0, d2} + {4'd0, carry_q};
	assign ge10  = (sum5 >= DEC_BASE);
	assign rsum5 = ge10 ? (sum5 - DEC_BASE) : sum5;
	assign sub5  = {1'b0, d2} + {4'd0, carry_q};
	assign lt    = ({1'b0, d1} < sub5);
	assign diff5 = lt ? ({1'b0, d1} + DEC_BASE - sub5) : ({1'b0, d1} - sub5);

	// Scratch write port: first-pass digits, then the carry digit of a sum.
	always_comb begin
		w_en   = 1'b0;
		w_addr = '0;
		w_data = 4'd0;
		if (add_v_s1) begin
			if (op_sum_q) begin
				w_en   = 1'b1;
				w_addr = len_q - p_s1;
				w_data = rsum5[3:0];
			end else begin
				w_en   = ain_s1;
				w_addr = a_count_q - CNT_W'(1) - p_s1;
				w_data = diff5[3:0];
			end
		end else if ((state_q == S_FIN) && op_sum_q) begin
			w_en   = 1'b1;
			w_addr = '0;
			w_data = {3'd0, carry_q};
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (req_type == REQ_LOAD_A) && (digit <= DIGIT_MAX) &&
		    (a_count_q < CNT_W'(MAX_DIGITS))) begin
			a_mem[a_count_q[DIG_AW-1:0]] <= digit;
		end
		if (accept && (req_type == REQ_LOAD_B) && (digit <= DIGIT_MAX) &&
		    (b_count_q < CNT_W'(MAX_DIGITS))) begin
			b_mem[b_count_q[DIG_AW-1:0]] <= digit;
		end
		if (w_en) begin
			work_mem[w_addr] <= w_data;
		end
		a_rd_q <= a_mem[a_off[DIG_AW-1:0]];
		b_rd_q <= b_mem[b_off[DIG_AW-1:0]];
		w_rd_q <= work_mem[e_q];
	end

	// Next state and result selection.
	always_comb begin
		state_d  = state_q;
		out_set  = 1'b0;
		out_st   = ST_NA;
		out_dig  = 4'd0;
		out_last = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (accept && ((req_type == REQ_SUM) || (req_type == REQ_DIFF))) begin
					if (na) begin
						out_set = 1'b1;
					end else begin
						state_d = S_ADD;
					end
				end
			end
			S_ADD: begin
				if (add_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!op_sum_q && carry_q) begin
					// A final borrow means A was below B.
					out_set = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (ev_s1) begin
					if (!(skip_q && (w_rd_q == 4'd0) && !elast_s1)) begin
						out_set  = 1'b1;
						out_st   = op_sum_q ? ST_SUM : ST_DIFF;
						out_dig  = w_rd_q;
						out_last = elast_s1;
					end
					if (elast_s1) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Operand counts and invalid marks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_count_q <= '0;
			b_count_q <= '0;
			a_inv_q   <= 1'b0;
			b_inv_q   <= 1'b0;
		end else if (accept) begin
			case (req_type)
				REQ_LOAD_A: begin
					if ((digit > DIGIT_MAX) || (a_count_q >= CNT_W'(MAX_DIGITS))) begin
						a_inv_q <= 1'b1;
					end else begin
						a_count_q <= a_count_q + CNT_W'(1);
					end
				end
				REQ_LOAD_B: begin
					if ((digit > DIGIT_MAX) || (b_count_q >= CNT_W'(MAX_DIGITS))) begin
						b_inv_q <= 1'b1;
					end else begin
						b_count_q <= b_count_q + CNT_W'(1);
					end
				end
				REQ_CLEAR: begin
					a_count_q <= '0;
					b_count_q <= '0;
					a_inv_q   <= 1'b0;
					b_inv_q   <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Pass control and read-stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_v_s1  <= 1'b0;
			ev_s1     <= 1'b0;
			e_issue_q <= 1'b0;
			strobe    <= 1'b0;
		end else begin
			add_v_s1 <= add_issue;
			ev_s1    <= emit_issue;
			strobe   <= out_set;
			if ((state_q == S_FIN) && (state_d == S_EMIT)) begin
				e_issue_q <= 1'b1;
			end else if (emit_issue && (e_q == end_q)) begin
				e_issue_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		p_s1     <= p_q;
		ain_s1   <= (p_q < a_count_q);
		bin_s1   <= (p_q < b_count_q);
		elast_s1 <= (e_q == end_q);
		if (out_set) begin
			status    <= out_st;
			digit_res <= out_dig;
			last      <= out_last;
		end
		if ((state_q == S_IDLE) && (state_d == S_ADD)) begin
			op_sum_q <= (req_type == REQ_SUM);
			len_q    <= max_len;
			p_q      <= '0;
			carry_q  <= 1'b0;
		end
		if (add_issue) begin
			p_q <= p_q + CNT_W'(1);
		end
		if (add_v_s1) begin
			carry_q <= op_sum_q ? ge10 : lt;
		end
		if (state_q == S_FIN) begin
			if (op_sum_q) begin
				// A zero carry digit is not sent.
				e_q    <= carry_q ? CNT_W'(0) : CNT_W'(1);
				end_q  <= len_q;
				skip_q <= 1'b0;
			end else begin
				e_q    <= '0;
				end_q  <= a_count_q - CNT_W'(1);
				skip_q <= 1'b1;
			end
		end
		if (emit_issue && (e_q != end_q)) begin
			e_q <= e_q + CNT_W'(1);
		end
		if ((state_q == S_EMIT) && out_set) begin
			skip_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_na_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (status == ST_NA)) |-> (last && (digit_res == 4'd0)))
		else $error("not-available result must be a single zero digit");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (status != ST_NA)) |-> (digit_res <= DIGIT_MAX))
		else $error("result digit out of decimal range");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> !busy)
		else $error("block still busy after final result");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(a_count_q <= CNT_W'(MAX_DIGITS)) && (b_count_q <= CNT_W'(MAX_DIGITS)))
		else $error("operand count beyond capacity");

	a_add_stage: assert property (@(posedge clk) disable iff (!arst_n)
		add_v_s1 |-> (state_q == S_ADD))
		else $error("first-pass read data outside the add pass");
`endif

endmodule
`default_nettype wire
